[design/cag_pkg.sv]
// ----------------------------------------------------------------------------
// cag_pkg
// Shared sizes, register indexes and types of the cave automaton step core.
// ----------------------------------------------------------------------------
package cag_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

    localparam int WIDTH_CFG_W  = 9;
    localparam int HEIGHT_CFG_W = 13;
    localparam int THRESH_W     = 4;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_ADDR_W   = 2;
    localparam int COUNT_W      = 4;

    // compare widths: wide enough for the register field and for the position
    localparam int WCMP_W = (COL_W + 1 > WIDTH_CFG_W) ? COL_W + 1 : WIDTH_CFG_W;
    localparam int HCMP_W = ((ROW_W > HEIGHT_CFG_W) ? ROW_W : HEIGHT_CFG_W) + 1;

    localparam logic [CFG_ADDR_W-1:0] REG_GRID_WIDTH        = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_HEIGHT       = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BIRTH_THRESHOLD   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SURVIVE_THRESHOLD = 2'd3;

    localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET   = 9'd64;
    localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET  = 13'd64;
    localparam logic [THRESH_W-1:0]     BIRTH_RESET   = 4'd5;
    localparam logic [THRESH_W-1:0]     SURVIVE_RESET = 4'd4;

    // one column of both line stores
    typedef struct packed {
        logic upper;
        logic middle;
    } line_pair_t;

    // per-item control carried from position logic to the window stage
    typedef struct packed {
        logic first_col;
        logic top_en;
        logic mid_en;
        logic res_valid;
        logic last;
        logic restart;
        logic bot;
    } step_ctrl_t;

    typedef struct packed {
        logic res_valid;
        logic new_cell;
        logic frame_last;
    } step_result_t;

endpackage

[design/cag_line_store.sv]
// ----------------------------------------------------------------------------
// cag_line_store
// Both line buffers in one synchronous RAM, one read and one write port,
// registered read, write-first on an address collision.
// ----------------------------------------------------------------------------
module cag_line_store
    import cag_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [COL_W-1:0] rd_addr,
    input  logic             wr_en,
    input  logic [COL_W-1:0] wr_addr,
    input  line_pair_t       wr_data,
    output line_pair_t       rd_data
);

    line_pair_t             mem [MAX_WIDTH];
    logic [MAX_WIDTH-1:0]   valid_reg;
    line_pair_t             rd_data_reg;

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else if (valid_reg[rd_addr])
            begin
                rd_data_reg <= mem[rd_addr];
            end
            else
            begin
                rd_data_reg <= '0;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/cag_window.sv]
// ----------------------------------------------------------------------------
// cag_window
// 3x3 window register, neighborhood count and birth/survive rule; also forms
// the write-back column for the line store.
// ----------------------------------------------------------------------------
module cag_window
    import cag_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  step_ctrl_t          ctrl,
    input  line_pair_t          line,
    input  logic [THRESH_W-1:0] birth_threshold,
    input  logic [THRESH_W-1:0] survive_threshold,
    output line_pair_t          wr_data,
    output step_result_t        result
);

    logic [8:0]         window_reg;
    logic [8:0]         window_next;
    logic [2:0]         new_col;
    logic [8:0]         shifted;
    logic [8:0]         use_cells;
    logic [COUNT_W-1:0] count;

    always_comb
    begin
        new_col   = {ctrl.bot, ctrl.mid_en & line.middle, ctrl.top_en & line.upper};
        shifted   = {new_col, window_reg[8:3]};
        // first column: the cell finished is the last one of the previous row,
        // its right neighbor lies outside the grid
        use_cells = ctrl.first_col ? {3'b000, window_reg[8:3]} : shifted;
        if (ctrl.restart)
        begin
            window_next = '0;
        end
        else if (ctrl.first_col)
        begin
            window_next = {new_col, 6'b000000};
        end
        else
        begin
            window_next = shifted;
        end
    end

    always_comb
    begin
        count = '0;
        for (int i = 0; i < 9; i++)
        begin
            count = count + COUNT_W'(use_cells[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (advance)
        begin
            window_reg <= window_next;
        end
    end

    assign result.res_valid  = ctrl.res_valid;
    assign result.new_cell   = use_cells[4] ? (count >= survive_threshold)
                                            : (count >= birth_threshold);
    assign result.frame_last = ctrl.last;

    assign wr_data.upper  = line.middle;
    assign wr_data.middle = ctrl.bot;

endmodule

[design/cave_automaton_generation_step_core.sv]
// ----------------------------------------------------------------------------
// cave_automaton_generation_step_core
// Path: stage 1 registers and line store read, then the result output register.
// Throughput: one item per cycle unless stalled (single line store RAM port pair).
// Each result refers to the cell one row and one cell behind the input.
// Reset: position, window, line store valid bits and registers to defaults.
// ----------------------------------------------------------------------------
module cave_automaton_generation_step_core
    import cag_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  cell_in,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  new_cell,
    output logic                  frame_last
);

    logic [WIDTH_CFG_W-1:0]  grid_width_reg;
    logic [HEIGHT_CFG_W-1:0] grid_height_reg;
    logic [THRESH_W-1:0]     birth_reg;
    logic [THRESH_W-1:0]     survive_reg;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    logic             s1_valid_reg;
    step_ctrl_t       s1_ctrl_reg;
    step_ctrl_t       s1_ctrl_next;
    logic [COL_W-1:0] s1_addr_reg;

    logic out_valid_reg;
    logic new_cell_reg;
    logic frame_last_reg;

    logic         accept;
    logic         s1_go;
    logic         advance;
    line_pair_t   rd_data;
    line_pair_t   wr_data;
    step_result_t result;

    logic [WCMP_W-1:0] w_eff;
    logic [WCMP_W-1:0] col_inc;
    logic [HCMP_W-1:0] h_eff;
    logic [HCMP_W-1:0] h_plus1;
    logic [HCMP_W-1:0] r_ext;
    logic              first_col;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= WIDTH_RESET;
            grid_height_reg <= HEIGHT_RESET;
            birth_reg       <= BIRTH_RESET;
            survive_reg     <= SURVIVE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_GRID_WIDTH:        grid_width_reg  <= cfg_wdata[WIDTH_CFG_W-1:0];
                REG_GRID_HEIGHT:       grid_height_reg <= cfg_wdata[HEIGHT_CFG_W-1:0];
                REG_BIRTH_THRESHOLD:   birth_reg       <= cfg_wdata[THRESH_W-1:0];
                REG_SURVIVE_THRESHOLD: survive_reg     <= cfg_wdata[THRESH_W-1:0];
                default:               ;
            endcase
        end
    end

    // handshake: stage 1 moves on unless its result has nowhere to go
    assign s1_go    = !s1_ctrl_reg.res_valid || !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && s1_go;
    assign in_stall = s1_valid_reg && !s1_go;
    assign accept   = in_valid && !in_stall;

    // clamped sizes and stream position
    always_comb
    begin
        if (grid_width_reg == '0)
        begin
            w_eff = WCMP_W'(1);
        end
        else if (WCMP_W'(grid_width_reg) > WCMP_W'(MAX_WIDTH))
        begin
            w_eff = WCMP_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WCMP_W'(grid_width_reg);
        end

        if (grid_height_reg == '0)
        begin
            h_eff = HCMP_W'(1);
        end
        else if (HCMP_W'(grid_height_reg) > HCMP_W'(MAX_HEIGHT))
        begin
            h_eff = HCMP_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = HCMP_W'(grid_height_reg);
        end

        h_plus1   = h_eff + HCMP_W'(1);
        r_ext     = HCMP_W'(row_reg);
        col_inc   = WCMP_W'(col_reg) + WCMP_W'(1);
        first_col = (col_reg == '0);

        s1_ctrl_next.first_col = first_col;
        s1_ctrl_next.top_en    = (r_ext >= HCMP_W'(2));
        s1_ctrl_next.mid_en    = (r_ext >= HCMP_W'(1));
        s1_ctrl_next.bot       = cell_in && (r_ext < h_eff);
        s1_ctrl_next.last      = first_col && (r_ext == h_plus1);
        s1_ctrl_next.restart   = first_col && (r_ext >= h_plus1);
        if (first_col)
        begin
            s1_ctrl_next.res_valid = (r_ext >= HCMP_W'(2)) && (r_ext <= h_plus1);
        end
        else
        begin
            s1_ctrl_next.res_valid = (r_ext >= HCMP_W'(1)) && (r_ext <= h_eff);
        end

        if (s1_ctrl_next.restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (col_inc >= w_eff)
        begin
            col_next = '0;
            row_next = row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_ctrl_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                col_reg     <= col_next;
                row_reg     <= row_next;
                s1_ctrl_reg <= s1_ctrl_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg <= col_reg;
        end
    end

    cag_line_store u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .wr_en   (advance),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    cag_window u_window (
        .clk               (clk),
        .rst_n             (rst_n),
        .advance           (advance),
        .ctrl              (s1_ctrl_reg),
        .line              (rd_data),
        .birth_threshold   (birth_reg),
        .survive_threshold (survive_reg),
        .wr_data           (wr_data),
        .result            (result)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && result.res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.res_valid)
        begin
            new_cell_reg   <= result.new_cell;
            frame_last_reg <= result.frame_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign new_cell   = new_cell_reg;
    assign frame_last = frame_last_reg;

endmodule
